[rtl/core/isp_pkg.sv]
// isp_pkg: shared types, constants and codes for the ini stream parser
// no dependencies; imported by isp_step, ini_stream_parser_unit, isp_result_checker and the testbench
package isp_pkg;

  localparam int POS_BITS = 16;
  localparam int REP_BITS = 16;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [2:0] ROLE_NONE  = 3'd0;
  localparam logic [2:0] ROLE_NAME  = 3'd1;
  localparam logic [2:0] ROLE_KEY   = 3'd2;
  localparam logic [2:0] ROLE_VALUE = 3'd3;
  localparam logic [2:0] ROLE_PUNCT = 3'd4;
  localparam logic [2:0] ROLE_NL    = 3'd5;

  localparam logic [3:0] ERR_NONE = 4'd0;

  typedef enum logic [2:0] {
    PS_SECTION_OR_END = 3'd0,
    PS_NAME_FIRST     = 3'd1,
    PS_NAME_MORE      = 3'd2,
    PS_HEADER_NL      = 3'd3,
    PS_KEY_OR_BLANK   = 3'd4,
    PS_KEY_MORE       = 3'd5,
    PS_VALUE_FIRST    = 3'd6,
    PS_VALUE_MORE     = 3'd7
  } parse_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          out_char;
    logic [2:0]          byte_role;
    logic                pair_done;
    logic                section_done;
    logic                accept;
    logic                error_flag;
    logic [3:0]          error_code;
    logic [REP_BITS-1:0] error_line;
    logic [REP_BITS-1:0] error_column;
  } out_item_t;

  typedef struct packed {
    parse_state_t        pstate;
    logic [POS_BITS-1:0] line_cnt;
    logic [POS_BITS-1:0] col_cnt;
    logic                err_seen;
    logic [3:0]          err_code;
    logic [POS_BITS-1:0] err_line;
    logic [POS_BITS-1:0] err_col;
  } parse_ctx_t;

  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam parse_ctx_t CTX_RESET = '{
    pstate:   PS_SECTION_OR_END,
    line_cnt: POS_ONE,
    col_cnt:  POS_ONE,
    err_seen: 1'b0,
    err_code: ERR_NONE,
    err_line: '0,
    err_col:  '0
  };

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic logic [3:0] code_for_state(input parse_state_t s);
    return 4'({1'b0, s}) + 4'd1;
  endfunction

  function automatic logic [REP_BITS-1:0] rep_pos(input logic [POS_BITS-1:0] p);
    logic [31:0] wide;
    wide = 32'(p);
    return wide[REP_BITS-1:0];
  endfunction

endpackage

[rtl/core/isp_step.sv]
// isp_step: one-byte grammar step, next parse context and result item
// depends on isp_pkg
module isp_step
  import isp_pkg::*;
(
  input  in_item_t   item,
  input  parse_ctx_t ctx,
  output parse_ctx_t ctx_nxt,
  output out_item_t  res
);

  logic [7:0]   c;
  logic         at_end;
  logic         ok;
  logic         idc;
  logic [2:0]   role;
  parse_state_t st_nxt;
  logic         pair_hit;
  logic         sect_hit;

  assign c      = item.in_byte;
  assign at_end = item.text_end || (c == 8'h00);
  assign idc    = is_ident(c);

  always_comb begin
    ok       = 1'b0;
    role     = ROLE_NONE;
    st_nxt   = ctx.pstate;
    pair_hit = 1'b0;
    sect_hit = 1'b0;
    unique case (ctx.pstate)
      PS_SECTION_OR_END: begin
        if (c == CH_LBRACK) begin
          ok = 1'b1; role = ROLE_PUNCT; st_nxt = PS_NAME_FIRST;
        end
      end
      PS_NAME_FIRST: begin
        if (idc) begin
          ok = 1'b1; role = ROLE_NAME; st_nxt = PS_NAME_MORE;
        end
      end
      PS_NAME_MORE: begin
        if (idc) begin
          ok = 1'b1; role = ROLE_NAME;
        end else if (c == CH_RBRACK) begin
          ok = 1'b1; role = ROLE_PUNCT; st_nxt = PS_HEADER_NL;
        end
      end
      PS_HEADER_NL: begin
        if (c == CH_NL) begin
          ok = 1'b1; role = ROLE_NL; st_nxt = PS_KEY_OR_BLANK;
        end
      end
      PS_KEY_OR_BLANK: begin
        if (idc) begin
          ok = 1'b1; role = ROLE_KEY; st_nxt = PS_KEY_MORE;
        end else if (c == CH_NL) begin
          ok = 1'b1; role = ROLE_NL; sect_hit = 1'b1; st_nxt = PS_SECTION_OR_END;
        end
      end
      PS_KEY_MORE: begin
        if (idc) begin
          ok = 1'b1; role = ROLE_KEY;
        end else if (c == CH_EQUALS) begin
          ok = 1'b1; role = ROLE_PUNCT; st_nxt = PS_VALUE_FIRST;
        end
      end
      PS_VALUE_FIRST: begin
        if (idc) begin
          ok = 1'b1; role = ROLE_VALUE; st_nxt = PS_VALUE_MORE;
        end
      end
      PS_VALUE_MORE: begin
        if (idc) begin
          ok = 1'b1; role = ROLE_VALUE;
        end else if (c == CH_NL) begin
          ok = 1'b1; role = ROLE_NL; pair_hit = 1'b1; st_nxt = PS_KEY_OR_BLANK;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res     = '0;
    ctx_nxt = ctx;
    if (at_end) begin
      ctx_nxt = CTX_RESET;
      if (ctx.err_seen) begin
        res.error_flag   = 1'b1;
        res.error_code   = ctx.err_code;
        res.error_line   = rep_pos(ctx.err_line);
        res.error_column = rep_pos(ctx.err_col);
      end else if (ctx.pstate == PS_SECTION_OR_END) begin
        res.accept = 1'b1;
      end else begin
        res.error_flag   = 1'b1;
        res.error_code   = code_for_state(ctx.pstate);
        res.error_line   = rep_pos(ctx.line_cnt);
        res.error_column = rep_pos(ctx.col_cnt);
      end
    end else begin
      res.out_char = c;
      if (!ctx.err_seen) begin
        if (ok) begin
          res.byte_role    = role;
          res.pair_done    = pair_hit;
          res.section_done = sect_hit;
          ctx_nxt.pstate   = st_nxt;
        end else begin
          ctx_nxt.err_seen = 1'b1;
          ctx_nxt.err_code = code_for_state(ctx.pstate);
          ctx_nxt.err_line = ctx.line_cnt;
          ctx_nxt.err_col  = ctx.col_cnt;
          res.error_flag   = 1'b1;
          res.error_code   = code_for_state(ctx.pstate);
          res.error_line   = rep_pos(ctx.line_cnt);
          res.error_column = rep_pos(ctx.col_cnt);
        end
      end
      // position counters, saturating
      if (c == CH_NL) begin
        if (ctx.line_cnt != POS_MAX) begin
          ctx_nxt.line_cnt = ctx.line_cnt + POS_ONE;
        end
        ctx_nxt.col_cnt = POS_ONE;
      end else if (ctx.col_cnt != POS_MAX) begin
        ctx_nxt.col_cnt = ctx.col_cnt + POS_ONE;
      end
    end
  end

endmodule

[rtl/core/ini_stream_parser_unit.sv]
// ini_stream_parser_unit: top level, parse context and output item register
// depends on isp_pkg and isp_step
// the result is registered: valid in the cycle after its item is accepted
// throughput: one item per cycle while out_ready holds; the result register frees as its item is taken
// reset: synchronous active-low rst_n returns the parser to expect section or end,
// line and column to 1, clears the saved error and empties the result register
module ini_stream_parser_unit
  import isp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  parse_ctx_t ctx_r;
  parse_ctx_t ctx_nxt;
  out_item_t  res_nxt;
  out_item_t  out_data_r;
  logic       out_valid_r;
  logic       in_fire;

  isp_step u_step (
    .item    (in_data),
    .ctx     (ctx_r),
    .ctx_nxt (ctx_nxt),
    .res     (res_nxt)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r       <= CTX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        ctx_r <= ctx_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

[tb/isp_result_checker.sv]
// isp_result_checker: watches both channels of ini_stream_parser_unit, predicts each
// result item from its own parser state and compares it field by field
// depends on isp_pkg
module isp_result_checker
  import isp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int unsigned results_pending,
  output int unsigned fault_count
);

  parse_state_t  ps;
  logic [15:0]   line_no;
  logic [15:0]   col_no;
  logic          err_hit;
  logic [3:0]    err_code_q;
  logic [15:0]   err_line_q;
  logic [15:0]   err_col_q;
  out_item_t     results_due[$];
  out_item_t     want;
  int unsigned   mismatches = 0;

  assign fault_count = mismatches;

  function automatic void restart_parser();
    ps         = PS_SECTION_OR_END;
    line_no    = POS_ONE;
    col_no     = POS_ONE;
    err_hit    = 1'b0;
    err_code_q = ERR_NONE;
    err_line_q = '0;
    err_col_q  = '0;
  endfunction

  function automatic logic ident_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic out_item_t parse_byte(input in_item_t it);
    out_item_t  r;
    logic       ok;
    logic [7:0] c;
    logic [3:0] code;
    r = '0;
    ok = 1'b0;
    c = it.in_byte;
    code = {1'b0, ps} + 4'd1;
    if (it.text_end || c == 8'h00) begin
      if (err_hit) begin
        r.error_flag   = 1'b1;
        r.error_code   = err_code_q;
        r.error_line   = err_line_q;
        r.error_column = err_col_q;
      end else if (ps == PS_SECTION_OR_END) begin
        r.accept = 1'b1;
      end else begin
        r.error_flag   = 1'b1;
        r.error_code   = code;
        r.error_line   = line_no;
        r.error_column = col_no;
      end
      restart_parser();
      return r;
    end
    r.out_char = c;
    if (!err_hit) begin
      case (ps)
        PS_SECTION_OR_END: begin
          if (c == CH_LBRACK) begin
            r.byte_role = ROLE_PUNCT; ps = PS_NAME_FIRST; ok = 1'b1;
          end
        end
        PS_NAME_FIRST: begin
          if (ident_char(c)) begin
            r.byte_role = ROLE_NAME; ps = PS_NAME_MORE; ok = 1'b1;
          end
        end
        PS_NAME_MORE: begin
          if (ident_char(c)) begin
            r.byte_role = ROLE_NAME; ok = 1'b1;
          end else if (c == CH_RBRACK) begin
            r.byte_role = ROLE_PUNCT; ps = PS_HEADER_NL; ok = 1'b1;
          end
        end
        PS_HEADER_NL: begin
          if (c == CH_NL) begin
            r.byte_role = ROLE_NL; ps = PS_KEY_OR_BLANK; ok = 1'b1;
          end
        end
        PS_KEY_OR_BLANK: begin
          if (ident_char(c)) begin
            r.byte_role = ROLE_KEY; ps = PS_KEY_MORE; ok = 1'b1;
          end else if (c == CH_NL) begin
            r.byte_role = ROLE_NL; r.section_done = 1'b1; ps = PS_SECTION_OR_END; ok = 1'b1;
          end
        end
        PS_KEY_MORE: begin
          if (ident_char(c)) begin
            r.byte_role = ROLE_KEY; ok = 1'b1;
          end else if (c == CH_EQUALS) begin
            r.byte_role = ROLE_PUNCT; ps = PS_VALUE_FIRST; ok = 1'b1;
          end
        end
        PS_VALUE_FIRST: begin
          if (ident_char(c)) begin
            r.byte_role = ROLE_VALUE; ps = PS_VALUE_MORE; ok = 1'b1;
          end
        end
        default: begin
          if (ident_char(c)) begin
            r.byte_role = ROLE_VALUE; ok = 1'b1;
          end else if (c == CH_NL) begin
            r.byte_role = ROLE_NL; r.pair_done = 1'b1; ps = PS_KEY_OR_BLANK; ok = 1'b1;
          end
        end
      endcase
      if (!ok) begin
        err_hit        = 1'b1;
        err_code_q     = code;
        err_line_q     = line_no;
        err_col_q      = col_no;
        r.error_flag   = 1'b1;
        r.error_code   = code;
        r.error_line   = line_no;
        r.error_column = col_no;
      end
    end
    if (c == CH_NL) begin
      if (line_no != POS_MAX) line_no = line_no + 16'd1;
      col_no = POS_ONE;
    end else if (col_no != POS_MAX) begin
      col_no = col_no + 16'd1;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_parser();
      results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result item with none expected: %h", out_data);
        end else begin
          want = results_due.pop_front();
          check_field("out_char", 16'(want.out_char), 16'(out_data.out_char));
          check_field("byte_role", 16'(want.byte_role), 16'(out_data.byte_role));
          check_field("pair_done", 16'(want.pair_done), 16'(out_data.pair_done));
          check_field("section_done", 16'(want.section_done),
                      16'(out_data.section_done));
          check_field("accept", 16'(want.accept), 16'(out_data.accept));
          check_field("error_flag", 16'(want.error_flag), 16'(out_data.error_flag));
          check_field("error_code", 16'(want.error_code), 16'(out_data.error_code));
          check_field("error_line", 16'(want.error_line), 16'(out_data.error_line));
          check_field("error_column", 16'(want.error_column),
                      16'(out_data.error_column));
        end
      end
      if (in_valid && in_ready) results_due.insert(results_due.size(), parse_byte(in_data));
    end
    results_pending <= results_due.size();
  end

endmodule

[tb/tb_ini_stream_parser_unit.sv]
// tb_ini_stream_parser_unit: drives INI text into ini_stream_parser_unit, directed and
// random, with idling and a long output stall
// depends on isp_pkg, ini_stream_parser_unit and isp_result_checker
module tb_ini_stream_parser_unit;
  import isp_pkg::*;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  int unsigned results_pending;
  int unsigned fault_count;

  int unsigned in_idle_pct = 19;
  int unsigned out_idle_pct = 83;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  logic [7:0]  text_buf[$];

  ini_stream_parser_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  isp_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .results_pending (results_pending),
    .fault_count     (fault_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, text_end: e};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] ident_byte();
    int unsigned k;
    k = $urandom_range(0, 63);
    if (k < 10) return 8'h30 + 8'(k);
    if (k < 36) return 8'h41 + 8'(k - 10);
    if (k < 62) return 8'h61 + 8'(k - 36);
    return (k == 62) ? CH_DASH : CH_UNDER;
  endfunction

  function automatic void add_ident();
    int unsigned n;
    n = $urandom_range(1, 5);
    repeat (n) text_buf.insert(text_buf.size(), ident_byte());
  endfunction

  function automatic void add_section();
    int unsigned pairs;
    pairs = $urandom_range(0, 3);
    text_buf.insert(text_buf.size(), CH_LBRACK);
    add_ident();
    text_buf.insert(text_buf.size(), CH_RBRACK);
    text_buf.insert(text_buf.size(), CH_NL);
    repeat (pairs) begin
      add_ident();
      text_buf.insert(text_buf.size(), CH_EQUALS);
      add_ident();
      text_buf.insert(text_buf.size(), CH_NL);
    end
    text_buf.insert(text_buf.size(), CH_NL);
  endfunction

  // mostly well-formed text, some corrupted, cut short or pure noise
  task automatic send_random_text();
    int unsigned kind;
    int unsigned n;
    text_buf.delete();
    n = $urandom_range(0, 3);
    repeat (n) add_section();
    kind = $urandom_range(0, 99);
    if (kind < 12 && text_buf.size() > 0) begin
      text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 20 && text_buf.size() > 0) begin
      text_buf.insert($urandom_range(0, text_buf.size() - 1), 8'($urandom_range(0, 255)));
    end else if (kind < 28 && text_buf.size() > 0) begin
      n = $urandom_range(1, text_buf.size());
      repeat (n) void'(text_buf.pop_back());
    end else if (kind < 34) begin
      text_buf.delete();
      n = $urandom_range(1, 8);
      repeat (n) text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
    end
    foreach (text_buf[i]) push_byte(text_buf[i], 1'b0);
    if ($urandom_range(0, 3) == 0) push_byte(8'h00, 1'b0);
    else push_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty text, good text ended by a zero byte, errors before and after end
    push_byte(8'hFF, 1'b1);
    push_str("[Z_-9]\nk=v\n\n");
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte("x", 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(CH_LBRACK, 1'b0);
    push_byte(8'h5A, 1'b1);
    push_str("[a");
    push_byte(8'h0D, 1'b0);
    push_byte(8'h00, 1'b1);

    while (items_sent < 400) send_random_text();
    in_idle_pct  = 83;
    out_idle_pct = 19;
    while (items_sent < 800) send_random_text();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_req     = 1'b1;
    while (items_sent < 1180) send_random_text();
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fault_count == 0 && results_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
